[rtl/fsde_pkg.sv]
// Shared character codes, widths and BCD constants for the decimal expander.
`timescale 1ns / 1ps

package fsde_pkg;

    // Character codes recognised or produced by the expander.
    localparam logic [7:0] CHAR_NUL     = 8'd0;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_MINUS   = 8'd45;
    localparam logic [7:0] CHAR_PERCENT = 8'd37;
    localparam logic [7:0] CHAR_D       = 8'd100;

    // Width and ceiling of the reported string length.
    localparam int unsigned     LEN_WIDTH = 16;
    localparam logic [15:0]     LEN_MAX   = 16'hFFFF;

    // Double-dabble correction: a BCD digit of five or more gets three added before each shift.
    localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJ       = 4'd3;

    typedef logic [7:0] char_t;

endpackage

[rtl/format_string_decimal_expander_top.sv]
// Top level of the format string decimal expander with its shared binary-to-BCD unit.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------------
//  in      | to block  | in_valid / in_stall   | fmt_char, arg_value
//  out     | from block| out_valid / out_stall | out_byte, run_end, string_end, written_length
//
// An ordinary byte, a NUL or a literal after '%' is taken when the result register is free.
// A "%d" is accepted and converted by shift-and-add-three over the argument bits; then leading
// zeros are skipped, a sign is sent for a negative argument and the digits follow. The next
// transaction is taken only after the last digit has been sent.
// rst_n clears the control state asynchronously. No memory needs clearing after reset.
// A stalled result is held and conversion goes on behind it; only bytes that need it wait.
`timescale 1ns / 1ps

module format_string_decimal_expander_top #(
    parameter int ARG_WIDTH   = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  fmt_char,
    input  logic signed [ARG_WIDTH-1:0] arg_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  out_byte,
    output logic                        run_end,
    output logic                        string_end,
    output logic [fsde_pkg::LEN_WIDTH-1:0] written_length
);

    // Decimal digits needed for the largest magnitude, 2^(ARG_WIDTH-1).
    localparam int NDIG   = ((ARG_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BCD_W  = 4 * NDIG;
    localparam int ITER_W = $clog2(ARG_WIDTH);
    localparam int DIG_W  = $clog2(NDIG + 1);
    localparam int EXT_W  = COUNT_WIDTH + fsde_pkg::LEN_WIDTH;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_SKIP  = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_DIGIT = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic                   pending_reg, pending_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   neg_reg, neg_next;
    logic [ARG_WIDTH-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;
    logic [DIG_W-1:0]       dig_left_reg, dig_left_next;

    logic                             out_valid_reg, out_valid_next;
    fsde_pkg::char_t                  out_byte_reg, out_byte_next;
    logic                             run_end_reg, run_end_next;
    logic                             string_end_reg, string_end_next;
    logic [fsde_pkg::LEN_WIDTH-1:0]   length_reg, length_next;

    logic                           in_fire;
    logic                           out_free;
    logic                           needs_slot;
    logic                           is_nul;
    logic                           is_percent;
    logic                           is_d;
    logic [COUNT_WIDTH-1:0]         count_inc;
    logic [EXT_W-1:0]               count_ext;
    logic [fsde_pkg::LEN_WIDTH-1:0] len_sat;
    logic [ARG_WIDTH-1:0]           magnitude;
    logic [BCD_W-1:0]               bcd_adj;
    logic [3:0]                     top_digit;
    logic [BCD_W-1:0]               bcd_shift_out;

    // Decode of the incoming format byte.
    assign is_nul     = (fmt_char == fsde_pkg::CHAR_NUL);
    assign is_percent = (fmt_char == fsde_pkg::CHAR_PERCENT);
    assign is_d       = (fmt_char == fsde_pkg::CHAR_D);

    // Only a swallowed '%' and the start of a conversion leave the result register alone.
    assign needs_slot = !((is_percent && !pending_reg) || (is_d && pending_reg && !is_nul));
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != S_IDLE) || (needs_slot && !out_free);
    assign in_fire    = in_valid && !in_stall;

    // Saturating byte count and the length reported with the NUL.
    assign count_inc = (count_reg == {COUNT_WIDTH{1'b1}}) ? count_reg
                                                          : count_reg + COUNT_WIDTH'(1);
    assign count_ext = EXT_W'(count_inc);
    assign len_sat   = (count_ext > EXT_W'(fsde_pkg::LEN_MAX)) ? fsde_pkg::LEN_MAX
                                                                : count_ext[fsde_pkg::LEN_WIDTH-1:0];

    // Magnitude of the argument; the most negative value comes out exact as unsigned.
    assign magnitude = arg_value[ARG_WIDTH-1] ? (~arg_value + ARG_WIDTH'(1)) : arg_value;

    // Shared BCD unit: every digit of five or more is corrected before the shift.
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[4*i +: 4] >= fsde_pkg::BCD_ADJ_LIMIT)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + fsde_pkg::BCD_ADJ;
            end
        end
    end

    assign top_digit     = bcd_reg[BCD_W-1 -: 4];
    assign bcd_shift_out = {bcd_reg[BCD_W-5:0], 4'b0000};

    // Sequencer and result register.
    always_comb
    begin
        state_next      = state_reg;
        pending_next    = pending_reg;
        count_next      = count_reg;
        neg_next        = neg_reg;
        bin_next        = bin_reg;
        bcd_next        = bcd_reg;
        iter_next       = iter_reg;
        dig_left_next   = dig_left_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_byte_next   = out_byte_reg;
        run_end_next    = run_end_reg;
        string_end_next = string_end_reg;
        length_next     = length_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (is_nul)
                    begin
                        out_valid_next  = 1'b1;
                        out_byte_next   = fsde_pkg::CHAR_NUL;
                        run_end_next    = 1'b1;
                        string_end_next = 1'b1;
                        length_next     = len_sat;
                        pending_next    = 1'b0;
                        count_next      = '0;
                    end
                    else if (pending_reg && is_d)
                    begin
                        pending_next = 1'b0;
                        neg_next     = arg_value[ARG_WIDTH-1];
                        bin_next     = magnitude;
                        bcd_next     = '0;
                        iter_next    = ITER_W'(ARG_WIDTH - 1);
                        state_next   = S_CONV;
                    end
                    else if (is_percent && !pending_reg)
                    begin
                        pending_next = 1'b1;
                    end
                    else
                    begin
                        pending_next    = 1'b0;
                        out_valid_next  = 1'b1;
                        out_byte_next   = fmt_char;
                        run_end_next    = 1'b1;
                        string_end_next = 1'b0;
                        length_next     = '0;
                        count_next      = count_inc;
                    end
                end
            end
            S_CONV:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[ARG_WIDTH-1]};
                bin_next = {bin_reg[ARG_WIDTH-2:0], 1'b0};
                if (iter_reg == '0)
                begin
                    dig_left_next = DIG_W'(NDIG);
                    state_next    = S_SKIP;
                end
                else
                begin
                    iter_next = iter_reg - ITER_W'(1);
                end
            end
            S_SKIP:
            begin
                // Drop leading zeros, always keeping the last digit.
                if ((top_digit == 4'd0) && (dig_left_reg > DIG_W'(1)))
                begin
                    bcd_next      = bcd_shift_out;
                    dig_left_next = dig_left_reg - DIG_W'(1);
                end
                else
                begin
                    state_next = neg_reg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = fsde_pkg::CHAR_MINUS;
                    run_end_next    = 1'b0;
                    string_end_next = 1'b0;
                    length_next     = '0;
                    count_next      = count_inc;
                    state_next      = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = fsde_pkg::CHAR_ZERO + {4'b0000, top_digit};
                    run_end_next    = (dig_left_reg == DIG_W'(1));
                    string_end_next = 1'b0;
                    length_next     = '0;
                    count_next      = count_inc;
                    bcd_next        = bcd_shift_out;
                    dig_left_next   = dig_left_reg - DIG_W'(1);
                    if (dig_left_reg == DIG_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pending_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
            dig_left_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            iter_reg      <= iter_next;
            dig_left_reg  <= dig_left_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        neg_reg        <= neg_next;
        bin_reg        <= bin_next;
        bcd_reg        <= bcd_next;
        out_byte_reg   <= out_byte_next;
        run_end_reg    <= run_end_next;
        string_end_reg <= string_end_next;
        length_reg     <= length_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign run_end        = run_end_reg;
    assign string_end     = string_end_reg;
    assign written_length = length_reg;

`ifndef SYNTH
    // The terminating NUL always closes the run of its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && string_end) |-> run_end)
        else $error("string end without run end");

    // The length field is zero on every byte but the NUL.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !string_end) |-> (written_length == '0))
        else $error("length on a non-terminating byte");

    // Digit emission never runs past its last digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIGIT) || (state_reg == S_SIGN)) |-> (dig_left_reg != '0))
        else $error("digit counter exhausted");

    // A conversion finishing leaves the block busy for at least the digit phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_CONV) && (iter_reg == '0)) |=> (state_reg == S_SKIP))
        else $error("conversion did not hand over to digit phase");
`endif

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the format string decimal expander.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned DECIMAL_BASE = 10;
    localparam int CLK_PERIOD = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 100;

    // One output transaction as the block presents it.
    typedef struct packed {
        fsde_pkg::char_t ch;
        logic            last;
        logic            term;
        logic [15:0]     len;
    } text_beat_t;

    // Tracks the formatter state and holds the bytes still owed by the block.
    class expansion_scoreboard;
        text_beat_t  owed_beats[$];
        bit          percent_seen;
        int unsigned bytes_out;
        int          mismatches;

        function void push_byte(fsde_pkg::char_t c, logic last);
            text_beat_t b;
            b.ch = c;
            b.last = last;
            b.term = 1'b0;
            b.len = '0;
            owed_beats.push_back(b);
            if (bytes_out < fsde_pkg::LEN_MAX)
                bytes_out++;
        endfunction

        function void expand_argument(logic signed [31:0] a);
            logic [31:0] mag;
            logic [3:0]  digits[10];
            int          nd;
            nd = 0;
            mag = a;
            if (a < 0)
            begin
                push_byte(fsde_pkg::CHAR_MINUS, 1'b0);
                mag = ~a + 32'd1;
            end
            // Collect digits least significant first; the most negative value is exact.
            do
            begin
                digits[nd] = 4'(mag % DECIMAL_BASE);
                mag = mag / DECIMAL_BASE;
                nd++;
            end
            while (mag != 0);
            for (int i = nd - 1; i >= 0; i--)
                push_byte(fsde_pkg::CHAR_ZERO + fsde_pkg::char_t'(digits[i]), i == 0);
        endfunction

        function void note_input(fsde_pkg::char_t c, logic signed [31:0] a);
            text_beat_t b;
            if (c == fsde_pkg::CHAR_NUL)
            begin
                // The NUL counts itself, then the string state starts afresh.
                if (bytes_out < fsde_pkg::LEN_MAX)
                    bytes_out++;
                b.ch = fsde_pkg::CHAR_NUL;
                b.last = 1'b1;
                b.term = 1'b1;
                b.len = 16'(bytes_out);
                owed_beats.push_back(b);
                percent_seen = 1'b0;
                bytes_out = 0;
            end
            else if (percent_seen)
            begin
                percent_seen = 1'b0;
                if (c == fsde_pkg::CHAR_D)
                    expand_argument(a);
                else
                    push_byte(c, 1'b1);
            end
            else if (c == fsde_pkg::CHAR_PERCENT)
                percent_seen = 1'b1;
            else
                push_byte(c, 1'b1);
        endfunction

        function void check_output(text_beat_t got);
            text_beat_t want;
            if (owed_beats.size() == 0)
            begin
                $display("%0t: unexpected output byte %0d", $time, got.ch);
                mismatches++;
                return;
            end
            want = owed_beats.pop_front();
            if (got.ch != want.ch)
            begin
                $display("%0t: out_byte expected %0d, got %0d", $time, want.ch, got.ch);
                mismatches++;
            end
            if (got.last != want.last)
            begin
                $display("%0t: run_end expected %0b, got %0b", $time, want.last, got.last);
                mismatches++;
            end
            if (got.term != want.term)
            begin
                $display("%0t: string_end expected %0b, got %0b", $time, want.term, got.term);
                mismatches++;
            end
            if (got.len != want.len)
            begin
                $display("%0t: written_length expected %0d, got %0d", $time, want.len, got.len);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    fsde_pkg::char_t    fmt_char = '0;
    logic signed [31:0] arg_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    fsde_pkg::char_t    out_byte;
    logic               run_end;
    logic               string_end;
    logic [fsde_pkg::LEN_WIDTH-1:0] written_length;

    expansion_scoreboard sb;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_request = 1'b0;

    format_string_decimal_expander_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .fmt_char       (fmt_char),
        .arg_value      (arg_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .run_end        (run_end),
        .string_end     (string_end),
        .written_length (written_length)
    );

    // Free-running clock.
    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Watchdog for a hung run.
    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Offers one format byte, after a random idle gap, and waits for it to be taken.
    task automatic send_item(fsde_pkg::char_t c, logic signed [31:0] a);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        fmt_char <= c;
        arg_value <= a;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(c, a);
    endtask

    // Argument values spread over every digit count, powers of ten and the extremes.
    function automatic logic signed [31:0] pick_arg();
        logic signed [31:0] v;
        logic signed [31:0] p10;
        p10 = 1;
        repeat ($urandom_range(0, 9)) p10 = p10 * DECIMAL_BASE;
        case ($urandom_range(0, 6))
            0: v = $urandom_range(0, 9);
            1: v = p10;
            2: v = p10 - 1;
            3:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            4: v = $urandom >> $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 2) == 0)
            v = -v;
        return v;
    endfunction

    // An ordinary text byte: anything but the NUL and the percent sign.
    function automatic fsde_pkg::char_t plain_char();
        fsde_pkg::char_t c;
        c = fsde_pkg::char_t'($urandom_range(1, 255));
        if (c == fsde_pkg::CHAR_PERCENT)
            c = "a";
        return c;
    endfunction

    // Random format strings: well-formed conversions and plain bytes, with some noise.
    task automatic run_random(int n);
        int sent;
        int pick;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                send_item(fsde_pkg::CHAR_PERCENT, $urandom);
                send_item(fsde_pkg::CHAR_D, pick_arg());
                sent += 2;
            end
            else if (pick < 45)
            begin
                send_item(fsde_pkg::CHAR_PERCENT, $urandom);
                send_item(fsde_pkg::char_t'($urandom_range(0, 255)), $urandom);
                sent += 2;
            end
            else if (pick < 85)
            begin
                send_item(plain_char(), $urandom);
                sent++;
            end
            else if (pick < 93)
            begin
                send_item(fsde_pkg::CHAR_NUL, $urandom);
                sent++;
            end
            else
            begin
                send_item(fsde_pkg::char_t'($urandom_range(0, 255)), $urandom);
                sent++;
            end
        end
    endtask

    // Output side: checks each accepted transaction and chooses the next stall.
    initial
    begin
        int hold_left;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_output({out_byte, run_end, string_end, written_length});
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Stimulus sequence and final verdict.
    initial
    begin
        int waited;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: byte extremes, each conversion case and string ends.
        send_item("A", 32'sd5);
        send_item(8'd255, '1);
        send_item(8'd1, '0);
        send_item(fsde_pkg::CHAR_PERCENT, '0);
        send_item(fsde_pkg::CHAR_D, 32'sd0);
        send_item(fsde_pkg::CHAR_PERCENT, '0);
        send_item(fsde_pkg::CHAR_D, 32'sh7FFF_FFFF);
        send_item(fsde_pkg::CHAR_PERCENT, '0);
        send_item(fsde_pkg::CHAR_D, 32'sh8000_0000);
        send_item(fsde_pkg::CHAR_PERCENT, '0);
        send_item(fsde_pkg::CHAR_D, 32'sd1000000000);
        send_item(fsde_pkg::CHAR_PERCENT, '0);
        send_item(fsde_pkg::CHAR_D, -32'sd1);
        send_item(fsde_pkg::CHAR_PERCENT, '0);
        send_item(fsde_pkg::CHAR_D, 32'sd10);
        send_item(fsde_pkg::CHAR_PERCENT, '0);
        send_item(fsde_pkg::CHAR_D, -32'sd10);
        send_item(fsde_pkg::CHAR_PERCENT, '0);
        send_item(fsde_pkg::CHAR_PERCENT, '1);
        send_item(fsde_pkg::CHAR_PERCENT, '0);
        send_item("x", 32'sd7);
        send_item(fsde_pkg::CHAR_PERCENT, '0);
        send_item(fsde_pkg::CHAR_NUL, '0);
        send_item(fsde_pkg::CHAR_NUL, '0);

        // Random phases; the first also holds the output off for a long stretch.
        hold_request = 1'b1;
        run_random(34);
        send_idle_pct = 45;
        recv_stall_pct = 0;
        run_random(34);
        send_idle_pct = 0;
        recv_stall_pct = 45;
        run_random(34);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        run_random(34);
        in_valid <= 1'b0;

        // Drain, then allow time for any stray output.
        waited = 0;
        while (sb.owed_beats.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.owed_beats.size() != 0)
            $display("%0t: %0d expected output bytes never arrived", $time,
                     sb.owed_beats.size());
        if (sb.mismatches == 0 && sb.owed_beats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
